@@ sv/bounded_array_statistics_macros.svh @@
// Assertion macros for the bounded array statistics checker.
// No dependencies; included by the checker file only.
`ifndef BOUNDED_ARRAY_STATISTICS_MACROS_SVH
`define BOUNDED_ARRAY_STATISTICS_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define BAS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bounded_array_statistics: check failed");

// Next-cycle implication, disabled while reset is asserted
`define BAS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bounded_array_statistics: check failed");

`endif

@@ sv/bas_pkg.sv @@
// Shared types, constants and the microcode table of the array statistics block.
// No dependencies; used by the interfaces, the sequencer, the top level and the checker.
package bas_pkg;

	localparam int unsigned MAX_ENTRIES_DFLT = 256;
	localparam int unsigned REQ_W = 2;
	localparam int unsigned IDX_W = 16;
	localparam int unsigned VAL_W = 32;
	localparam int unsigned LEN_W = 9;
	localparam logic [LEN_W-1:0] LEN_RESET = 9'd256;
	// 10000.0 in Q16.16
	localparam logic signed [VAL_W-1:0] READ_DEFAULT = 32'sd655360000;

	typedef enum logic [REQ_W-1:0] {
		REQ_WRITE = 2'd0,
		REQ_READ  = 2'd1,
		REQ_STATS = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

	typedef enum logic [3:0] {
		A_NONE       = 4'd0,
		A_CLEAR      = 4'd1,
		A_ACCEPT     = 4'd2,
		A_WRITE      = 4'd3,
		A_READ       = 4'd4,
		A_READ_TAKE  = 4'd5,
		A_SCAN_START = 4'd6,
		A_SCAN       = 4'd7,
		A_DIV_START  = 4'd8,
		A_MEAN       = 4'd9,
		A_PUSH       = 4'd10
	} act_t;

	typedef enum logic [2:0] {
		C_ALWAYS   = 3'd0,
		C_FIRE     = 3'd1,
		C_LAST     = 3'd2,
		C_DIV_DONE = 3'd3,
		C_OUT_FREE = 3'd4,
		C_DISPATCH = 3'd5
	} cond_t;

	typedef logic [3:0] step_t;

	localparam step_t U_CLR       = 4'd0;
	localparam step_t U_IDLE      = 4'd1;
	localparam step_t U_DECODE    = 4'd2;
	localparam step_t U_WRITE     = 4'd3;
	localparam step_t U_READ      = 4'd4;
	localparam step_t U_READ_TAKE = 4'd5;
	localparam step_t U_STAT_INIT = 4'd6;
	localparam step_t U_SCAN      = 4'd7;
	localparam step_t U_DIV_START = 4'd8;
	localparam step_t U_DIV_WAIT  = 4'd9;
	localparam step_t U_MEAN      = 4'd10;
	localparam step_t U_RESULT    = 4'd11;

	// One control word: action for the datapath, jump condition and target.
	// A false condition holds the step.
	typedef struct packed {
		act_t  act;
		cond_t cond;
		step_t target;
	} ctrl_t;

	typedef struct packed {
		req_t req;
		logic fire;
		logic last;
		logic div_done;
		logic out_free;
	} stat_t;

	function automatic ctrl_t ucode(input step_t s);
		ctrl_t w;
		w = '{A_NONE, C_ALWAYS, U_IDLE};
		unique case (s)
			U_CLR:       w = '{A_CLEAR,      C_LAST,     U_IDLE};
			U_IDLE:      w = '{A_ACCEPT,     C_FIRE,     U_DECODE};
			U_DECODE:    w = '{A_NONE,       C_DISPATCH, U_RESULT};
			U_WRITE:     w = '{A_WRITE,      C_ALWAYS,   U_RESULT};
			U_READ:      w = '{A_READ,       C_ALWAYS,   U_READ_TAKE};
			U_READ_TAKE: w = '{A_READ_TAKE,  C_ALWAYS,   U_RESULT};
			U_STAT_INIT: w = '{A_SCAN_START, C_ALWAYS,   U_SCAN};
			U_SCAN:      w = '{A_SCAN,       C_LAST,     U_DIV_START};
			U_DIV_START: w = '{A_DIV_START,  C_ALWAYS,   U_DIV_WAIT};
			U_DIV_WAIT:  w = '{A_NONE,       C_DIV_DONE, U_MEAN};
			U_MEAN:      w = '{A_MEAN,       C_ALWAYS,   U_RESULT};
			U_RESULT:    w = '{A_PUSH,       C_OUT_FREE, U_IDLE};
			default:     w = '{A_NONE,       C_ALWAYS,   U_IDLE};
		endcase
		return w;
	endfunction

endpackage

@@ sv/bas_ifs.sv @@
// Handshake channels of the array statistics block: request, response, configuration.
// Depends on bas_pkg for field widths.
interface bas_req_if import bas_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [REQ_W-1:0]        req_type;
	logic signed [IDX_W-1:0] index;
	logic signed [VAL_W-1:0] value;

	modport source (output valid, req_type, index, value, input ready);
	modport sink (input valid, req_type, index, value, output ready);
endinterface

interface bas_rsp_if import bas_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [VAL_W-1:0] read_value;
	logic signed [VAL_W-1:0] min_value;
	logic signed [VAL_W-1:0] max_value;
	logic signed [VAL_W-1:0] mean_value;
	logic                    index_bad;

	modport source (output valid, read_value, min_value, max_value, mean_value, index_bad,
		input ready);
	modport sink (input valid, read_value, min_value, max_value, mean_value, index_bad,
		output ready);
endinterface

interface bas_cfg_if import bas_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [LEN_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

@@ sv/bas_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bas_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 256,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rd_q <= mem_q[raddr];
		end
	end

	assign rdata = rd_q;

endmodule

@@ sv/bas_div.sv @@
// Restoring divider, one quotient bit per cycle, for the mean computation.
// No dependencies.
module bas_div #(
	parameter int unsigned NW = 41,
	parameter int unsigned DW = 9
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic          done,
	output logic [NW-1:0] quotient
);

	localparam int unsigned CW = $clog2(NW + 1);

	logic          busy_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] rem_q;
	logic [NW-1:0] quo_q;
	logic [DW-1:0] dsr_q;
	logic [DW:0]   shifted;
	logic [DW:0]   diff;
	logic          take;

	// Bring down the next dividend bit and try a subtract
	always_comb begin
		shifted = {rem_q, quo_q[NW-1]};
		diff    = shifted - {1'b0, dsr_q};
		take    = (shifted >= {1'b0, dsr_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(NW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= take ? diff[DW-1:0] : shifted[DW-1:0];
			quo_q <= {quo_q[NW-2:0], take};
		end
	end

	assign done     = !busy_q;
	assign quotient = quo_q;

endmodule

@@ sv/bas_seq.sv @@
// Microcode sequencer: step counter, control word lookup and conditional jumps.
// Depends on bas_pkg for the control word, status struct and microcode table.
module bas_seq import bas_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  stat_t stat,
	output ctrl_t ctrl
);

	step_t step_q;
	step_t step_d;
	ctrl_t word;
	logic  taken;
	step_t dispatch;

	always_comb begin
		word = ucode(step_q);

		unique case (stat.req)
			REQ_WRITE: dispatch = U_WRITE;
			REQ_READ:  dispatch = U_READ;
			REQ_STATS: dispatch = U_STAT_INIT;
			REQ_NONE:  dispatch = U_RESULT;
			default:   dispatch = U_RESULT;
		endcase

		unique case (word.cond)
			C_ALWAYS:   taken = 1'b1;
			C_FIRE:     taken = stat.fire;
			C_LAST:     taken = stat.last;
			C_DIV_DONE: taken = stat.div_done;
			C_OUT_FREE: taken = stat.out_free;
			C_DISPATCH: taken = 1'b1;
			default:    taken = 1'b0;
		endcase

		// Hold the step until its condition comes true
		if (!taken) begin
			step_d = step_q;
		end else if (word.cond == C_DISPATCH) begin
			step_d = dispatch;
		end else begin
			step_d = word.target;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= U_CLR;
		end else begin
			step_q <= step_d;
		end
	end

	assign ctrl = word;

endmodule

@@ sv/bounded_array_statistics.sv @@
// Top level of the array statistics block: datapath, entry store, divider, sequencer.
// Depends on bas_pkg, bas_ifs, bas_ram, bas_div and bas_seq.
//
//   channel  direction  carries
//   cfg      in         array_length (9 bits), written whenever valid is high
//   req      in         req_type, index, value
//   rsp      out        read_value, min_value, max_value, mean_value, index_bad
//
// After reset a clearing pass zeroes the store, one entry a cycle, with req.ready low;
// configuration writes are taken throughout.
// One request at a time. A write steps through decode, write and result; a read through
// decode, read, read take and result; an unused code through decode and result.
// Statistics do one store read a cycle on the scan, then one quotient bit a cycle in
// the divider (32 + clog2(MAX_ENTRIES + 1) bits).
// A result waits in the output register; the next request is taken meanwhile and its
// own result holds in the sequencer until the output register frees.
module bounded_array_statistics import bas_pkg::*; #(
	parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DFLT
) (
	input logic      clk,
	input logic      arst_n,
	bas_cfg_if.sink  cfg,
	bas_req_if.sink  req,
	bas_rsp_if.source rsp
);

	localparam int unsigned LW    = $clog2(MAX_ENTRIES + 1);
	localparam int unsigned AW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int unsigned SUM_W = VAL_W + LW;

	ctrl_t ctrl;
	stat_t stat;

	logic [LEN_W-1:0] len_q;
	logic [LW-1:0]    act_len;
	logic [LW-1:0]    cnt_q;
	logic             out_vld_q;
	logic             fire;
	logic             idx_ok;
	logic             out_free;
	logic             clr_last;
	logic             scan_last;

	req_t                    req_q;
	logic [AW-1:0]           idx_q;
	logic                    ok_q;
	logic signed [VAL_W-1:0] val_q;
	logic                    first_q;
	logic signed [VAL_W-1:0] min_q;
	logic signed [VAL_W-1:0] max_q;
	logic signed [SUM_W-1:0] sum_q;

	logic signed [VAL_W-1:0] res_read_q;
	logic signed [VAL_W-1:0] res_min_q;
	logic signed [VAL_W-1:0] res_max_q;
	logic signed [VAL_W-1:0] res_mean_q;
	logic                    res_bad_q;

	logic signed [VAL_W-1:0] out_read_q;
	logic signed [VAL_W-1:0] out_min_q;
	logic signed [VAL_W-1:0] out_max_q;
	logic signed [VAL_W-1:0] out_mean_q;
	logic                    out_bad_q;

	logic                    ram_we;
	logic [AW-1:0]           ram_waddr;
	logic [VAL_W-1:0]        ram_wdata;
	logic                    ram_re;
	logic [AW-1:0]           ram_raddr;
	logic [VAL_W-1:0]        ram_rdata;
	logic signed [VAL_W-1:0] rd_val;

	logic             div_start;
	logic             div_done;
	logic [SUM_W-1:0] div_mag;
	logic [SUM_W-1:0] div_quo;
	logic [VAL_W-1:0] quo_lo;

	// Zero or an oversize length selects the full store
	always_comb begin
		if (len_q == '0 || 32'(len_q) > MAX_ENTRIES) begin
			act_len = LW'(MAX_ENTRIES);
		end else begin
			act_len = LW'(len_q);
		end
	end

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= LEN_RESET;
		end else if (cfg.valid) begin
			len_q <= cfg.data;
		end
	end

	assign req.ready = (ctrl.act == A_ACCEPT);
	assign fire      = req.valid && req.ready;
	assign idx_ok    = !req.index[IDX_W-1]
		&& (32'(req.index[IDX_W-2:0]) < 32'(act_len));
	assign out_free  = !out_vld_q || rsp.ready;
	assign clr_last  = (cnt_q == LW'(MAX_ENTRIES - 1));
	assign scan_last = (cnt_q == act_len);
	assign rd_val    = $signed(ram_rdata);

	assign stat = '{
		req:      req_q,
		fire:     fire,
		last:     (ctrl.act == A_CLEAR) ? clr_last : scan_last,
		div_done: div_done,
		out_free: out_free
	};

	bas_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	// Store ports: the clearing pass and writes share the write port
	always_comb begin
		ram_we    = (ctrl.act == A_CLEAR) || (ctrl.act == A_WRITE && ok_q);
		ram_waddr = (ctrl.act == A_CLEAR) ? cnt_q[AW-1:0] : idx_q;
		ram_wdata = (ctrl.act == A_CLEAR) ? '0 : val_q;
		ram_re    = (ctrl.act == A_READ) || (ctrl.act == A_SCAN_START)
			|| (ctrl.act == A_SCAN && cnt_q < act_len);
		unique case (ctrl.act)
			A_READ:       ram_raddr = idx_q;
			A_SCAN_START: ram_raddr = '0;
			default:      ram_raddr = cnt_q[AW-1:0];
		endcase
	end

	bas_ram #(
		.WIDTH (VAL_W),
		.DEPTH (MAX_ENTRIES)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign div_start = (ctrl.act == A_DIV_START);
	assign div_mag   = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
	assign quo_lo    = div_quo[VAL_W-1:0];

	bas_div #(
		.NW (SUM_W),
		.DW (LW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_mag),
		.divisor  (act_len),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			unique case (ctrl.act)
				A_CLEAR:      cnt_q <= cnt_q + 1'b1;
				A_SCAN_START: cnt_q <= LW'(1);
				A_SCAN:       cnt_q <= cnt_q + 1'b1;
				default:      cnt_q <= cnt_q;
			endcase
			if (ctrl.act == A_PUSH && out_free) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Request capture, scan accumulators and result
	always_ff @(posedge clk) begin
		unique case (ctrl.act)
			A_ACCEPT: begin
				if (fire) begin
					req_q      <= req_t'(req.req_type);
					idx_q      <= AW'(req.index[IDX_W-2:0]);
					ok_q       <= idx_ok;
					val_q      <= req.value;
					res_read_q <= '0;
					res_min_q  <= '0;
					res_max_q  <= '0;
					res_mean_q <= '0;
					res_bad_q  <= 1'b0;
				end
			end
			A_WRITE: begin
				res_bad_q <= !ok_q;
			end
			A_READ_TAKE: begin
				res_read_q <= ok_q ? rd_val : READ_DEFAULT;
				res_bad_q  <= !ok_q;
			end
			A_SCAN_START: begin
				first_q <= 1'b1;
				sum_q   <= '0;
			end
			A_SCAN: begin
				first_q <= 1'b0;
				sum_q   <= sum_q + SUM_W'(rd_val);
				if (first_q || rd_val < min_q) begin
					min_q <= rd_val;
				end
				if (first_q || rd_val > max_q) begin
					max_q <= rd_val;
				end
			end
			A_MEAN: begin
				res_min_q  <= min_q;
				res_max_q  <= max_q;
				res_mean_q <= sum_q[SUM_W-1] ? $signed(-quo_lo) : $signed(quo_lo);
			end
			A_PUSH: begin
				if (out_free) begin
					out_read_q <= res_read_q;
					out_min_q  <= res_min_q;
					out_max_q  <= res_max_q;
					out_mean_q <= res_mean_q;
					out_bad_q  <= res_bad_q;
				end
			end
			default: begin
				req_q <= req_q;
			end
		endcase
	end

	assign rsp.valid      = out_vld_q;
	assign rsp.read_value = out_read_q;
	assign rsp.min_value  = out_min_q;
	assign rsp.max_value  = out_max_q;
	assign rsp.mean_value = out_mean_q;
	assign rsp.index_bad  = out_bad_q;

endmodule

@@ sv/bas_chk.sv @@
// Port-level checker for the array statistics block, bound to the top level.
// Depends on bounded_array_statistics_macros.svh and bas_pkg.
`include "bounded_array_statistics_macros.svh"

module bas_chk import bas_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    rsp_valid,
	input logic                    rsp_ready,
	input logic signed [VAL_W-1:0] read_value,
	input logic signed [VAL_W-1:0] min_value,
	input logic signed [VAL_W-1:0] max_value,
	input logic signed [VAL_W-1:0] mean_value,
	input logic                    index_bad
);

	// Hold a stalled item
	`BAS_ASSERT_NXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid)
	`BAS_ASSERT_NXT(a_rsp_stable, clk, arst_n, rsp_valid && !rsp_ready, $stable(read_value) && $stable(min_value) && $stable(max_value) && $stable(mean_value) && $stable(index_bad))
	// A bad index never comes with statistics, and a read gives the default
	`BAS_ASSERT_IMP(a_bad_fields, clk, arst_n, rsp_valid && index_bad, min_value == 0 && max_value == 0 && mean_value == 0 && (read_value == 0 || read_value == READ_DEFAULT))
	// The mean lies between minimum and maximum
	`BAS_ASSERT_IMP(a_mean_range, clk, arst_n, rsp_valid, min_value <= mean_value && mean_value <= max_value)

endmodule

bind bounded_array_statistics bas_chk u_bas_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.read_value (rsp.read_value),
	.min_value  (rsp.min_value),
	.max_value  (rsp.max_value),
	.mean_value (rsp.mean_value),
	.index_bad  (rsp.index_bad)
);
